// ===== rtl/ptsched_pkg.sv =====
// Shared types and constants of the periodic task scheduler.
// No dependencies; used by the top level through scoped names.
`timescale 1ns / 1ps
`default_nettype none

package ptsched_pkg;

  // Fixed field widths
  localparam int WORK_W  = 16;
  localparam int TIME_W  = 32;
  localparam int INDEX_W = 3;
  localparam int MASK_W  = 8;
  localparam int TCNT_W  = 4;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  // Request kinds
  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_LOAD    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  // Register indexes (taken from paddr[2])
  localparam logic REG_POLICY     = 1'b0;
  localparam logic REG_TASK_COUNT = 1'b1;

  // Time value after reset and after a restart
  localparam logic [TIME_W-1:0] TIME_START = 32'd1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SWEEP,
    S_RESTART,
    S_PUSH
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/ptsched_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ptsched_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 8
) (
  input  wire                                        clk,
  input  wire                                        we,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire [WIDTH-1:0]                            wdata,
  input  wire                                        re,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/periodic_task_scheduler_rm_edf.sv =====
// Periodic task scheduler, rate monotonic or earliest deadline first.
// Depends on ptsched_pkg and ptsched_ram.
//
// Every request (tick, load, restart) gives exactly one result. The task
// table (period, work, work left, deadline, phase) sits in one RAM with a
// registered read, one row per task. A tick with n tasks in use runs a
// scan pass over the n rows that picks the task, then a read-modify-write
// sweep over them that runs it and counts the phases, then loads the
// result register and returns to idle to accept the next request. A load
// or an unused request goes straight to the result register, a restart
// after one sweep over every row (MAX_TASKS rows). A tick with no task in
// use goes straight to the result register.
// The result register lets a new request be accepted while the previous
// result is still stalled; the block only waits when a second result is
// ready before the first has been taken. Configuration is over an APB
// port, policy at 0x0 and task_count at 0x4.
`timescale 1ns / 1ps
`default_nettype none

module periodic_task_scheduler_rm_edf #(
  parameter int MAX_TASKS   = 8,
  parameter int PERIOD_BITS = 16
) (
  input  wire                               clk,
  input  wire                               rst,
  // APB configuration port
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire [ptsched_pkg::ADDR_W-1:0]     paddr,
  input  wire [ptsched_pkg::DATA_W-1:0]     pwdata,
  output logic [ptsched_pkg::DATA_W-1:0]    prdata,
  output logic                              pready,
  // Request channel
  input  wire                               req_valid,
  output logic                              req_stall,
  input  wire [1:0]                         mode,
  input  wire [ptsched_pkg::INDEX_W-1:0]    task_index,
  input  wire [ptsched_pkg::WORK_W-1:0]     task_period,
  input  wire [ptsched_pkg::WORK_W-1:0]     task_work,
  // Result channel
  output logic                              res_valid,
  input  wire                               res_stall,
  output logic                              ran_valid,
  output logic [ptsched_pkg::INDEX_W-1:0]   ran_index,
  output logic                              ran_completed,
  output logic [ptsched_pkg::WORK_W-1:0]    ran_work_left,
  output logic [ptsched_pkg::MASK_W-1:0]    missed_mask,
  output logic [ptsched_pkg::TIME_W-1:0]    tick_time
);

  localparam int P      = PERIOD_BITS;
  localparam int WW     = ptsched_pkg::WORK_W;
  localparam int TW     = ptsched_pkg::TIME_W;
  localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  // Row layout: {period, work, work_left, deadline, phase}
  localparam int PH_LO  = 0;
  localparam int DL_LO  = P;
  localparam int WL_LO  = P + TW;
  localparam int WK_LO  = P + TW + WW;
  localparam int PD_LO  = P + TW + 2 * WW;
  localparam int ROW_W  = 2 * P + TW + 2 * WW;

  ptsched_pkg::state_t state, state_next;

  // Configuration registers
  logic                              policy;
  logic [ptsched_pkg::TCNT_W-1:0]    task_count;

  // Sequencer
  logic [CNT_W-1:0]  ctr;
  logic              pend;
  logic [CNT_W-1:0]  pend_idx;
  logic [CNT_W-1:0]  n_use;
  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  last;
  logic              pass_end;
  logic              rd_en;
  logic              accept;
  logic              out_free;

  // Task table RAM
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic [ROW_W-1:0]  rd_row;

  // Flags and time
  logic [MAX_TASKS-1:0] done;
  logic [TW-1:0]        now;

  // Pick of the current tick
  logic              found;
  logic [TW-1:0]     best;
  logic [IDX_W-1:0]  pick;

  // Result waiting for the result register
  logic                              hold_valid;
  logic                              hold_completed;
  logic [WW-1:0]                     hold_left;
  logic [ptsched_pkg::MASK_W-1:0]    hold_missed;
  logic [TW-1:0]                     hold_time;

  // Fields of the row coming out of the RAM
  logic [P-1:0]      r_period;
  logic [WW-1:0]     r_work;
  logic [WW-1:0]     r_left;
  logic [TW-1:0]     r_dl;
  logic [P-1:0]      r_phase;
  logic [IDX_W-1:0]  p_idx;

  // Sweep arithmetic for one row
  logic              is_pick;
  logic [WW-1:0]     wl_dec;
  logic              comp;
  logic [WW-1:0]     new_left;
  logic [TW-1:0]     new_dl;
  logic              done_mid;
  logic [P-1:0]      ph_inc;
  logic              bound;
  logic [P-1:0]      new_phase;
  logic [TW-1:0]     key;
  logic [ROW_W-1:0]  sweep_row;
  logic [ROW_W-1:0]  rewind_row;
  logic [ROW_W-1:0]  load_row;
  logic [P-1:0]      ld_period;
  logic              load_ok;

  assign pready    = 1'b1;
  assign req_stall = (state != ptsched_pkg::S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !res_valid || !res_stall;

  // Register read-back
  always_comb begin
    if (paddr[2] == ptsched_pkg::REG_TASK_COUNT) begin
      prdata = {{(ptsched_pkg::DATA_W - ptsched_pkg::TCNT_W){1'b0}}, task_count};
    end else begin
      prdata = {{(ptsched_pkg::DATA_W - 1){1'b0}}, policy};
    end
  end

  // Tasks in use, clipped to the table size
  assign n_use = (32'(task_count) > MAX_TASKS) ? CNT_W'(MAX_TASKS) : CNT_W'(task_count);

  // Row field unpacking
  assign r_period = rd_row[PD_LO +: P];
  assign r_work   = rd_row[WK_LO +: WW];
  assign r_left   = rd_row[WL_LO +: WW];
  assign r_dl     = rd_row[DL_LO +: TW];
  assign r_phase  = rd_row[PH_LO +: P];
  assign p_idx    = pend_idx[IDX_W-1:0];

  // Scan key: period for rate monotonic, deadline for EDF
  assign key = policy ? r_dl : TW'(r_period);

  // One row of the sweep: run the picked task, then count its phase
  always_comb begin
    is_pick   = found && (p_idx == pick);
    wl_dec    = r_left - WW'(1);
    comp      = is_pick && (wl_dec == '0);
    new_left  = is_pick ? (comp ? r_work : wl_dec) : r_left;
    new_dl    = comp ? (r_dl + TW'(r_period)) : r_dl;
    done_mid  = comp || done[p_idx];
    ph_inc    = r_phase + P'(1);
    bound     = (ph_inc == r_period);
    new_phase = bound ? '0 : ph_inc;
    sweep_row = {r_period, r_work, new_left, new_dl, new_phase};
  end

  // Rows written by a restart and by a load
  assign rewind_row = {r_period, r_work, r_work, TW'(r_period), {P{1'b0}}};
  assign ld_period  = P'(task_period);
  assign load_row   = {ld_period, task_work, task_work, TW'(ld_period), {P{1'b0}}};
  assign load_ok    = (32'(task_index) < MAX_TASKS);

  // Next state, RAM control
  always_comb begin
    state_next = state;
    lim        = (state == ptsched_pkg::S_RESTART) ? CNT_W'(MAX_TASKS) : n_use;
    last       = lim - CNT_W'(1);
    pass_end   = pend && (pend_idx == last);
    rd_en      = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = p_idx;
    ram_wdata  = sweep_row;
    case (state)
      ptsched_pkg::S_IDLE: begin
        if (req_valid) begin
          case (mode)
            ptsched_pkg::MODE_TICK: begin
              state_next = (n_use == '0) ? ptsched_pkg::S_PUSH : ptsched_pkg::S_SCAN;
            end
            ptsched_pkg::MODE_LOAD: begin
              state_next = ptsched_pkg::S_PUSH;
              ram_we     = load_ok;
              ram_waddr  = IDX_W'(task_index);
              ram_wdata  = load_row;
            end
            ptsched_pkg::MODE_RESTART: begin
              state_next = ptsched_pkg::S_RESTART;
            end
            default: begin
              state_next = ptsched_pkg::S_PUSH;
            end
          endcase
        end
      end
      ptsched_pkg::S_SCAN: begin
        rd_en = (ctr < lim);
        if (pass_end) begin
          state_next = ptsched_pkg::S_SWEEP;
        end
      end
      ptsched_pkg::S_SWEEP: begin
        rd_en  = (ctr < lim);
        ram_we = pend;
        if (pass_end) begin
          state_next = ptsched_pkg::S_PUSH;
        end
      end
      ptsched_pkg::S_RESTART: begin
        rd_en     = (ctr < lim);
        ram_we    = pend;
        ram_wdata = rewind_row;
        if (pass_end) begin
          state_next = ptsched_pkg::S_PUSH;
        end
      end
      ptsched_pkg::S_PUSH: begin
        if (out_free) begin
          state_next = ptsched_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ptsched_pkg::S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptsched_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  ptsched_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (ctr[IDX_W-1:0]),
    .rdata (rd_row)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      policy     <= 1'b0;
      task_count <= ptsched_pkg::TCNT_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == ptsched_pkg::REG_TASK_COUNT) begin
        task_count <= pwdata[ptsched_pkg::TCNT_W-1:0];
      end else begin
        policy <= pwdata[0];
      end
    end
  end

  // Pass counters and read pipeline tag
  always_ff @(posedge clk) begin
    if (rst) begin
      ctr  <= '0;
      pend <= 1'b0;
    end else begin
      if (accept || (state == ptsched_pkg::S_SCAN && pass_end)) begin
        ctr <= '0;
      end else if (rd_en) begin
        ctr <= ctr + CNT_W'(1);
      end
      pend <= rd_en;
    end
    pend_idx <= ctr;
  end

  // Done flags, time and the pick of a tick
  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= '0;
      now   <= ptsched_pkg::TIME_START;
      found <= 1'b0;
    end else begin
      if (accept) begin
        found <= 1'b0;
        case (mode)
          ptsched_pkg::MODE_TICK: begin
            now <= now + TW'(1);
          end
          ptsched_pkg::MODE_LOAD: begin
            if (load_ok) begin
              done[IDX_W'(task_index)] <= 1'b0;
            end
          end
          ptsched_pkg::MODE_RESTART: begin
            done <= '0;
            now  <= ptsched_pkg::TIME_START;
          end
          default: begin
          end
        endcase
      end
      // Scan: keep the ready task with the smallest key
      if (state == ptsched_pkg::S_SCAN && pend && !done[p_idx] &&
          (!found || key < best)) begin
        found <= 1'b1;
        best  <= key;
        pick  <= p_idx;
      end
      // Sweep: completion sets done, a period boundary clears it
      if (state == ptsched_pkg::S_SWEEP && pend) begin
        done[p_idx] <= bound ? 1'b0 : done_mid;
      end
    end
  end

  // Result being built
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_valid     <= 1'b0;
      hold_completed <= 1'b0;
      hold_left      <= '0;
      hold_missed    <= '0;
      hold_time      <= (mode == ptsched_pkg::MODE_TICK) ? now : '0;
    end
    if (state == ptsched_pkg::S_SWEEP && pend) begin
      if (is_pick) begin
        hold_valid     <= 1'b1;
        hold_completed <= comp;
        hold_left      <= comp ? '0 : wl_dec;
      end
      // Bits past the mask width fall off the shift
      if (bound && !done_mid) begin
        hold_missed <= hold_missed | (ptsched_pkg::MASK_W'(1) << pend_idx);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ptsched_pkg::S_PUSH && out_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (state == ptsched_pkg::S_PUSH && out_free) begin
      ran_valid     <= hold_valid;
      ran_index     <= hold_valid ? ptsched_pkg::INDEX_W'(pick) : '0;
      ran_completed <= hold_completed;
      ran_work_left <= hold_left;
      missed_mask   <= hold_missed;
      tick_time     <= hold_time;
    end
  end

`ifndef SYNTH
  // The scan pass only reads the table
  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ptsched_pkg::S_SCAN) |-> !ram_we)
    else $error("table written during scan");

  // A picked task lies among the entries in use
  a_pick_in_use: assert property (@(posedge clk) disable iff (rst)
    (state == ptsched_pkg::S_SWEEP && found) |-> (CNT_W'(pick) < n_use))
    else $error("picked task outside the entries in use");

  // A tick advances time by one
  a_tick_time: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == ptsched_pkg::MODE_TICK) |=> (now == $past(now) + TW'(1)))
    else $error("time did not advance on a tick");

  // A restart clears every done flag
  a_restart_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == ptsched_pkg::MODE_RESTART) |=> (done == '0))
    else $error("done flags survived a restart");

  // A finished result reaches the result register once the slot is free
  a_push: assert property (@(posedge clk) disable iff (rst)
    (state == ptsched_pkg::S_PUSH && out_free) |=> res_valid)
    else $error("result not presented");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench of periodic_task_scheduler_rm_edf: directed and random tick, load and restart
// requests, with an in-bench rate monotonic / EDF predictor checking each result.
// Depends on ptsched_pkg and periodic_task_scheduler_rm_edf.

module tb;

  localparam logic [1:0] MODE_SPARE = 2'd3;  // unused request kind, changes nothing
  localparam int TASKS    = 8;
  localparam int WATCHDOG = 4000;
  localparam int SHOWN    = 10;

  typedef struct packed {
    logic [1:0]                         op;
    logic [ptsched_pkg::INDEX_W-1:0]    idx;
    logic [ptsched_pkg::WORK_W-1:0]     period;
    logic [ptsched_pkg::WORK_W-1:0]     work;
    logic                               hold;   // wait for every result before issuing
  } sched_req_t;

  typedef struct packed {
    logic                               ran;
    logic [ptsched_pkg::INDEX_W-1:0]    idx;
    logic                               completed;
    logic [ptsched_pkg::WORK_W-1:0]     left;
    logic [ptsched_pkg::MASK_W-1:0]     missed;
    logic [ptsched_pkg::TIME_W-1:0]     tick_time;
  } sched_res_t;

  // Clock and DUT-facing signals
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                               psel    = 1'b0;
  logic                               penable = 1'b0;
  logic                               pwrite  = 1'b0;
  logic [ptsched_pkg::ADDR_W-1:0]     paddr   = '0;
  logic [ptsched_pkg::DATA_W-1:0]     pwdata  = '0;
  logic [ptsched_pkg::DATA_W-1:0]     prdata;
  logic                               pready;

  logic                               req_valid   = 1'b0;
  logic                               req_stall;
  logic [1:0]                         mode        = '0;
  logic [ptsched_pkg::INDEX_W-1:0]    task_index  = '0;
  logic [ptsched_pkg::WORK_W-1:0]     task_period = '0;
  logic [ptsched_pkg::WORK_W-1:0]     task_work   = '0;

  logic                               res_valid;
  logic                               res_stall = 1'b0;
  logic                               ran_valid;
  logic [ptsched_pkg::INDEX_W-1:0]    ran_index;
  logic                               ran_completed;
  logic [ptsched_pkg::WORK_W-1:0]     ran_work_left;
  logic [ptsched_pkg::MASK_W-1:0]     missed_mask;
  logic [ptsched_pkg::TIME_W-1:0]     tick_time;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  periodic_task_scheduler_rm_edf u_top (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .mode          (mode),
    .task_index    (task_index),
    .task_period   (task_period),
    .task_work     (task_work),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .ran_valid     (ran_valid),
    .ran_index     (ran_index),
    .ran_completed (ran_completed),
    .ran_work_left (ran_work_left),
    .missed_mask   (missed_mask),
    .tick_time     (tick_time)
  );

  // Scheduler shadow state
  bit               cfg_policy = 1'b0;
  bit [3:0]         cfg_count  = 4'd1;
  bit [15:0]        task_per   [TASKS];
  bit [15:0]        task_len   [TASKS];
  bit [15:0]        job_left   [TASKS];
  bit [31:0]        task_due   [TASKS];
  bit               job_done   [TASKS];
  bit [15:0]        task_phase [TASKS];
  bit [31:0]        clock_now  = ptsched_pkg::TIME_START;

  sched_req_t pending_requests[$];
  sched_res_t expected_runs[$];
  sched_req_t cur_req;
  bit         req_busy    = 1'b0;
  int         gap_left    = 0;
  int         calm_left   = 0;
  int         stall_left  = 0;
  int         free_left   = 0;
  int         idle_cycles = 0;
  int         mismatch_cnt = 0;

  // Stimulus bookkeeping: entries loaded since reset, entries in use
  bit [TASKS-1:0] gen_loaded = '0;
  int             gen_tasks  = 1;

  function automatic void rewind_task(int i);
    task_due[i]   = {16'd0, task_per[i]};
    job_left[i]   = task_len[i];
    job_done[i]   = 1'b0;
    task_phase[i] = 16'd0;
  endfunction

  // One request through the scheduler; returns the result it should give
  function automatic sched_res_t advance_schedule(sched_req_t rq);
    sched_res_t r;
    int         n;
    int         pick;
    bit         found;
    bit [31:0]  best;
    bit [31:0]  key;
    r = '0;
    pick = 0;
    found = 1'b0;
    best = '0;
    case (rq.op)
      ptsched_pkg::MODE_LOAD: begin
        task_per[rq.idx] = rq.period;
        task_len[rq.idx] = rq.work;
        rewind_task(int'(rq.idx));
      end
      ptsched_pkg::MODE_RESTART: begin
        for (int i = 0; i < TASKS; i++) rewind_task(i);
        clock_now = ptsched_pkg::TIME_START;
      end
      ptsched_pkg::MODE_TICK: begin
        n = (cfg_count > TASKS) ? TASKS : int'(cfg_count);
        // pick: smallest period or earliest deadline, lowest index on a tie
        for (int i = 0; i < n; i++) begin
          key = cfg_policy ? task_due[i] : {16'd0, task_per[i]};
          if (!job_done[i] && (!found || key < best)) begin
            found = 1'b1;
            best = key;
            pick = i;
          end
        end
        if (found) begin
          job_left[pick] = job_left[pick] - 16'd1;
          if (job_left[pick] == 16'd0) begin
            job_left[pick] = task_len[pick];
            task_due[pick] = task_due[pick] + {16'd0, task_per[pick]};
            job_done[pick] = 1'b1;
            r.completed = 1'b1;
          end else begin
            r.left = job_left[pick];
          end
          r.ran = 1'b1;
          r.idx = pick[ptsched_pkg::INDEX_W-1:0];
        end
        // period boundaries
        for (int i = 0; i < n; i++) begin
          task_phase[i] = task_phase[i] + 16'd1;
          if (task_phase[i] == task_per[i]) begin
            if (!job_done[i]) r.missed[i] = 1'b1;
            job_done[i] = 1'b0;
            task_phase[i] = 16'd0;
          end
        end
        r.tick_time = clock_now;
        clock_now = clock_now + 32'd1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Sender gap length; mostly none, sometimes long, with calm stretches
  function automatic int next_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = 60;
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void push_request(logic [1:0] op, int idx, logic [15:0] per,
                                       logic [15:0] work, bit hold);
    sched_req_t rq;
    rq.op = op;
    rq.idx = idx[ptsched_pkg::INDEX_W-1:0];
    rq.period = per;
    rq.work = work;
    rq.hold = hold;
    if (op == ptsched_pkg::MODE_LOAD) gen_loaded[idx] = 1'b1;
    pending_requests.push_back(rq);
  endfunction

  function automatic void push_load(int idx);
    logic [15:0] per;
    logic [15:0] work;
    if ($urandom_range(0, 99) < 88) begin
      per = 16'($urandom_range(1, 24));
      work = 16'($urandom_range(1, per));
    end else begin
      per = 16'($urandom);
      work = 16'($urandom);
    end
    push_request(ptsched_pkg::MODE_LOAD, idx, per, work, 1'b0);
  endfunction

  // A tick only once every entry in use has been loaded
  function automatic void push_tick(bit hold);
    int hole;
    hole = -1;
    for (int i = gen_tasks - 1; i >= 0; i--)
      if (!gen_loaded[i]) hole = i;
    if (hole >= 0) push_load(hole);
    else push_request(ptsched_pkg::MODE_TICK, $urandom_range(0, 7), 16'($urandom),
                      16'($urandom), hold);
  endfunction

  task automatic drain_all();
    while (pending_requests.size() != 0 || req_busy || expected_runs.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(logic regsel, logic [ptsched_pkg::DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {regsel, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(bit pol, bit [3:0] count);
    drain_all();
    reg_write(ptsched_pkg::REG_POLICY, {31'd0, pol});
    reg_write(ptsched_pkg::REG_TASK_COUNT, {28'd0, count});
    cfg_policy = pol;
    cfg_count = count;
    gen_tasks = (count > TASKS) ? TASKS : int'(count);
  endtask

  // Request driver
  always @(negedge clk) begin
    bit launch;
    launch = 1'b0;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_busy) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_requests.size() != 0 &&
                   !(pending_requests[0].hold && expected_runs.size() != 0)) begin
        launch = 1'b1;
      end
      if (launch) begin
        cur_req = pending_requests.pop_front();
        mode        <= cur_req.op;
        task_index  <= cur_req.idx;
        task_period <= cur_req.period;
        task_work   <= cur_req.work;
        req_busy = 1'b1;
      end
      req_valid <= launch;
    end
  end

  // Result stall pattern
  always @(negedge clk) begin
    bit hold_off;
    hold_off = 1'b0;
    if (stall_left > 0) begin
      stall_left--;
      hold_off = 1'b1;
    end else if (free_left > 0) begin
      free_left--;
    end else begin
      free_left = ($urandom_range(0, 99) < 10) ? 150 : $urandom_range(0, 8);
      stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3)
                                                : $urandom_range(10, 50);
    end
    res_stall <= hold_off;
  end

  // Prediction on request, comparison on result, stall watchdog
  always @(posedge clk) begin
    sched_res_t got;
    sched_res_t want;
    bit         moved;
    bit         bad;
    moved = 1'b0;
    if (!rst && req_valid && !req_stall) begin
      expected_runs.push_back(advance_schedule(cur_req));
      req_busy = 1'b0;
      gap_left = next_gap();
      moved = 1'b1;
    end
    if (!rst && res_valid && !res_stall) begin
      moved = 1'b1;
      got = '{ran_valid, ran_index, ran_completed, ran_work_left, missed_mask, tick_time};
      want = '0;
      bad = 1'b1;
      if (expected_runs.size() != 0) begin
        want = expected_runs.pop_front();
        bad = got.ran !== want.ran || got.idx !== want.idx ||
              got.completed !== want.completed || got.left !== want.left ||
              got.missed !== want.missed || got.tick_time !== want.tick_time;
      end else if (mismatch_cnt < SHOWN) begin
        $display("%0t: result with no request outstanding", $realtime);
      end
      if (bad) begin
        if (mismatch_cnt < SHOWN)
          $display("%0t: exp %0d %0d %0d %0d %02h %0d | got %0d %0d %0d %0d %02h %0d",
                   $realtime, want.ran, want.idx, want.completed, want.left, want.missed,
                   want.tick_time, got.ran, got.idx, got.completed, got.left, got.missed,
                   got.tick_time);
        mismatch_cnt++;
      end
    end
    idle_cycles = (moved || rst) ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    int tc;
    int budget;
    int r;
    bit pol;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // non-tick kinds, extreme table values
    push_request(MODE_SPARE, 7, 16'hffff, 16'hffff, 1'b0);
    push_request(ptsched_pkg::MODE_RESTART, 0, 16'h0000, 16'h0000, 1'b0);
    push_request(ptsched_pkg::MODE_LOAD, 0, 16'hffff, 16'hffff, 1'b0);
    push_request(ptsched_pkg::MODE_LOAD, 7, 16'h0000, 16'h0000, 1'b0);
    push_tick(1'b0);
    push_tick(1'b0);
    // job fits its period, then one that overruns and misses
    push_request(ptsched_pkg::MODE_LOAD, 0, 16'd3, 16'd1, 1'b0);
    repeat (3) push_tick(1'b0);
    push_request(ptsched_pkg::MODE_LOAD, 0, 16'd2, 16'd3, 1'b1);
    repeat (3) push_tick(1'b0);

    // no entry in use: an idle tick
    set_config(1'b1, 4'd0);
    push_tick(1'b0);
    // zero period ranks first under rate monotonic; restart mid schedule
    set_config(1'b0, 4'd3);
    push_request(ptsched_pkg::MODE_LOAD, 1, 16'h0000, 16'd2, 1'b0);
    push_request(ptsched_pkg::MODE_LOAD, 2, 16'hffff, 16'd1, 1'b0);
    repeat (3) push_tick(1'b0);
    push_request(ptsched_pkg::MODE_RESTART, 5, 16'h1234, 16'h4321, 1'b0);
    push_tick(1'b0);
    // count above the table size acts as a full table
    set_config(1'b1, 4'd15);
    repeat (3) push_tick(1'b0);

    // random phases over both policies and several task counts
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0, 1:    tc = 8;
        2:       tc = 1;
        3:       tc = 15;
        4:       tc = 0;
        5, 6:    tc = $urandom_range(2, 7);
        default: tc = $urandom_range(1, 15);
      endcase
      pol = ph[0] ^ (ph >= 4);
      set_config(pol, 4'(tc));
      for (int i = 0; i < gen_tasks; i++)
        if (!gen_loaded[i] || $urandom_range(0, 1) == 0) push_load(i);
      budget = (gen_tasks == 0) ? 30 : 150;
      for (int k = 0; k < budget; k++) begin
        r = $urandom_range(0, 99);
        if (r < 76) push_tick(1'b0);
        else if (r < 84) push_load($urandom_range(0, TASKS - 1));
        else if (r < 88) push_request(ptsched_pkg::MODE_RESTART, $urandom_range(0, 7),
                                      16'($urandom), 16'($urandom), 1'b0);
        else if (r < 93) push_request(MODE_SPARE, $urandom_range(0, 7), 16'($urandom),
                                      16'($urandom), 1'b0);
        else if (r < 95) push_tick(1'b1);
        else push_tick(1'b0);
      end
    end

    drain_all();
    repeat (30) @(posedge clk);
    if (mismatch_cnt == 0 && expected_runs.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== periodic_task_scheduler_rm_edf.f =====
rtl/ptsched_pkg.sv
rtl/ptsched_ram.sv
rtl/periodic_task_scheduler_rm_edf.sv
dv/tb.sv
